/* hw/rtl/collective_elementwise_reduce_macros.svh */
// Assertion helpers for the elementwise reduce block.
`ifndef COLLECTIVE_ELEMENTWISE_REDUCE_MACROS_SVH
`define COLLECTIVE_ELEMENTWISE_REDUCE_MACROS_SVH

// Same-cycle implication.
`define CER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cer_pkg.sv */
`default_nettype none
package cer_pkg;

   localparam int RANK_W     = 4;
   localparam int IDX_W      = 10;
   localparam int VAL_W      = 64;
   localparam int STAT_W     = 2;
   localparam int DT_W       = 3;
   localparam int MODE_W     = 1;
   localparam int RIU_W      = 5;
   localparam int SLICE_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int NR_W       = 9;
   localparam int EXT_W      = 17;

   localparam logic [DT_W-1:0] DT_UINT8 = 3'd0;
   localparam logic [DT_W-1:0] DT_INT32 = 3'd1;
   localparam logic [DT_W-1:0] DT_INT64 = 3'd2;
   localparam logic [DT_W-1:0] DT_FP16  = 3'd3;
   localparam logic [DT_W-1:0] DT_FP32  = 3'd4;

   localparam logic [MODE_W-1:0] MODE_SUM = 1'b0;
   localparam logic [MODE_W-1:0] MODE_MAX = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
   localparam logic [STAT_W-1:0] ST_ORDER     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FLOAT_MAX = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_TYPE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANKS       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE       = 2'd3;

   localparam logic [31:0] QNAN32   = 32'h7fc0_0000;
   localparam logic [31:0] INF32    = 32'h7f80_0000;
   localparam logic [15:0] QNAN16   = 16'h7e00;
   localparam logic [15:0] INF16    = 16'h7c00;
   localparam logic [12:0] HALF_RND = 13'h1000;
   localparam logic [23:0] HIDDEN   = 24'h80_0000;

   // Adder state between alignment and normalize/round.
   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic        sub;
      logic [9:0]  ex;
      logic [27:0] rs;
   } fp_mid_type;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  e;
      logic [9:0]  f;
      logic [3:0]  p;
      logic [3:0]  sh;
      logic [9:0]  f2;
      logic [7:0]  ub;
      sgn = {h[15], 31'd0};
      e   = h[14:10];
      f   = h[9:0];
      p   = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (f[i]) p = 4'(i);
      end
      sh = 4'd10 - p;
      f2 = 10'(f << sh);
      ub = 8'd113 - {4'd0, sh};
      if (e == 5'd0) begin
         if (f == 10'd0) return sgn;
         return sgn | {1'b0, ub, f2, 13'd0};
      end
      if (e == 5'h1f) return (f == 10'd0) ? (sgn | INF32) : QNAN32;
      return sgn | {1'b0, 8'({3'd0, e} + 8'd112), f, 13'd0};
   endfunction

   function automatic logic [15:0] single_to_half(input logic [31:0] b);
      logic [15:0] sgn;
      logic [7:0]  e;
      logic [22:0] f;
      int          ub;
      logic [5:0]  he;
      logic [10:0] hf;
      logic [12:0] rem;
      logic [24:0] sig;
      int          sh;
      logic [24:0] srem;
      logic [24:0] half;
      logic [24:0] shf;
      sgn = {b[31], 15'd0};
      e   = b[30:23];
      f   = b[22:0];
      ub  = int'(e) - 127;
      if (e == 8'hff) return (f == 23'd0) ? (sgn | INF16) : QNAN16;
      if (e == 8'd0) return sgn;
      if (ub > 15) return sgn | INF16;
      if (ub >= -14) begin
         he  = 6'(ub + 15);
         hf  = {1'b0, f[22:13]};
         rem = f[12:0];
         if (rem > HALF_RND || (rem == HALF_RND && hf[0])) begin
            hf = hf + 11'd1;
            if (hf == 11'h400) begin
               hf = 11'd0;
               he = he + 6'd1;
               if (he == 6'h1f) return sgn | INF16;
            end
         end
         return sgn | {1'b0, he[4:0], hf[9:0]};
      end
      if (ub < -25) return sgn;
      sig  = {1'b0, HIDDEN | {1'b0, f}};
      sh   = -1 - ub;
      shf  = sig >> sh;
      srem = sig & ((25'd1 << sh) - 25'd1);
      half = 25'd1 << (sh - 1);
      if (srem > half || (srem == half && shf[0])) shf = shf + 25'd1;
      return sgn | shf[15:0];
   endfunction

   // Specials, operand swap, alignment and the significand add.
   function automatic fp_mid_type fp_align(input logic [31:0] l, input logic [31:0] r);
      fp_mid_type  m;
      logic [7:0]  le;
      logic [7:0]  re;
      logic        lz0;
      logic        rz0;
      logic [31:0] a;
      logic [31:0] b;
      logic [7:0]  ae;
      logic [7:0]  be;
      logic [9:0]  bx;
      logic [9:0]  d;
      logic [27:0] as;
      logic [27:0] bs;
      logic [27:0] bsj;
      m   = '0;
      le  = l[30:23];
      re  = r[30:23];
      lz0 = (l[30:0] == 31'd0);
      rz0 = (r[30:0] == 31'd0);
      if ((le == 8'hff && l[22:0] != 23'd0) || (re == 8'hff && r[22:0] != 23'd0)) begin
         m.special     = 1'b1;
         m.special_val = QNAN32;
      end else if (le == 8'hff || re == 8'hff) begin
         m.special = 1'b1;
         if (le == 8'hff && re == 8'hff && (l[31] ^ r[31])) m.special_val = QNAN32;
         else m.special_val = (le == 8'hff) ? l : r;
      end else if (lz0 && rz0) begin
         m.special     = 1'b1;
         m.special_val = {l[31] & r[31], 31'd0};
      end else if (lz0) begin
         m.special     = 1'b1;
         m.special_val = r;
      end else if (rz0) begin
         m.special     = 1'b1;
         m.special_val = l;
      end else begin
         a    = (l[30:0] < r[30:0]) ? r : l;
         b    = (l[30:0] < r[30:0]) ? l : r;
         ae   = a[30:23];
         be   = b[30:23];
         m.ex = (ae == 8'd0) ? 10'd1 : {2'd0, ae};
         bx   = (be == 8'd0) ? 10'd1 : {2'd0, be};
         as   = {1'b0, ae != 8'd0, a[22:0], 3'd0};
         bs   = {1'b0, be != 8'd0, b[22:0], 3'd0};
         d    = m.ex - bx;
         if (d >= 10'd27) bsj = {27'd0, bs != 28'd0};
         else bsj = (bs >> d) | {27'd0, (bs & ((28'd1 << d) - 28'd1)) != 28'd0};
         m.sign = a[31];
         m.sub  = a[31] ^ b[31];
         m.rs   = m.sub ? (as - bsj) : (as + bsj);
         if (m.sub && m.rs == 28'd0) begin
            m.special     = 1'b1;
            m.special_val = 32'd0;
         end
      end
      return m;
   endfunction

   // Normalize and round to nearest even.
   function automatic logic [31:0] fp_finish(input fp_mid_type m);
      logic [27:0] rs;
      logic [9:0]  ex;
      logic [4:0]  p;
      logic [9:0]  lz;
      logic [9:0]  sh;
      logic [24:0] sig;
      logic [2:0]  rb;
      logic [7:0]  ee;
      rs = m.rs;
      ex = m.ex;
      p  = 5'd0;
      if (m.special) return m.special_val;
      if (!m.sub) begin
         if (rs[27]) begin
            rs = (rs >> 1) | {27'd0, rs[0]};
            ex = ex + 10'd1;
         end
      end else begin
         for (int i = 0; i < 27; i++) begin
            if (rs[i]) p = 5'(i);
         end
         lz = 10'd26 - {5'd0, p};
         sh = (lz < ex - 10'd1) ? lz : (ex - 10'd1);
         rs = rs << sh;
         ex = ex - sh;
      end
      sig = {1'b0, rs[26:3]};
      rb  = rs[2:0];
      if (rb > 3'd4 || (rb == 3'd4 && sig[0])) begin
         sig = sig + 25'd1;
         if (sig == 25'h100_0000) begin
            sig = sig >> 1;
            ex  = ex + 10'd1;
         end
      end
      if (ex >= 10'd255) return {m.sign, INF32[30:0]};
      ee = (ex == 10'd1 && sig < {1'b0, HIDDEN}) ? 8'd0 : ex[7:0];
      return {m.sign, ee, sig[22:0]};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/cer_req_if.sv */
`default_nettype none
interface cer_req_if import cer_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RANK_W-1:0] rank;
   logic [IDX_W-1:0]  element_index;
   logic [VAL_W-1:0]  element_value;

   modport source (output valid, rank, element_index, element_value, input ready);
   modport sink (input valid, rank, element_index, element_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cer_rsp_if.sv */
`default_nettype none
interface cer_rsp_if import cer_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  out_index;
   logic [VAL_W-1:0]  reduced_value;
   logic [STAT_W-1:0] status;

   modport source (output valid, out_index, reduced_value, status, input ready);
   modport sink (input valid, out_index, reduced_value, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/cer_fp_add.sv */
`default_nettype none
// binary32 add: align/add, registered, then normalize/round.
module cer_fp_add import cer_pkg::*; (
   input  wire logic        clock,
   input  wire logic [31:0] lhs,
   input  wire logic [31:0] rhs,
   output logic      [31:0] sum
);
   fp_mid_type mid_ff;
   fp_mid_type mid_in;

   assign mid_in = fp_align(lhs, rhs);

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

   assign sum = fp_finish(mid_ff);
endmodule
`default_nettype wire

/* hw/rtl/cer_store.sv */
`default_nettype none
// Accumulator and expected-rank memories, registered read.
module cer_store import cer_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [VAL_W-1:0]  acc_rdata,
   output logic      [RANK_W-1:0] rank_rdata,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic              acc_we,
   input  wire logic [VAL_W-1:0]  acc_wdata,
   input  wire logic              rank_we,
   input  wire logic [RANK_W-1:0] rank_wdata
);
   logic [VAL_W-1:0]  acc_mem  [DEPTH];
   logic [RANK_W-1:0] rank_mem [DEPTH];
   logic [VAL_W-1:0]  acc_rd_ff;
   logic [RANK_W-1:0] rank_rd_ff;

   always_ff @(posedge clock) begin
      if (acc_we) acc_mem[wr_addr] <= acc_wdata;
      if (rd_en) acc_rd_ff <= acc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (rank_we) rank_mem[wr_addr] <= rank_wdata;
      if (rd_en) rank_rd_ff <= rank_mem[rd_addr];
   end

   assign acc_rdata  = acc_rd_ff;
   assign rank_rdata = rank_rd_ff;
endmodule
`default_nettype wire

/* hw/rtl/collective_elementwise_reduce.sv */
// Element-wise all-reduce (sum or max) across ranks, one element per item.
// req_chan (valid/ready): rank, element_index, element_value. Ranks of one
// element must come in order 0,1,..; rank 0 seeds the accumulator.
// rsp_chan (valid/ready): out_index, reduced_value, status. A result comes
// when the last rank of an element arrives, or at once for a bad item
// (status 1 range, 2 out of order/duplicate, 3 float with max; value zero).
// csr_*: write-only registers; the user must see that they are written only
// while no item is in flight, which the block does not enforce. Any write
// clears all expected ranks (a sweep of all MAX_ELEMENTS entries, no items
// accepted). Flow: a good item is one read-modify-write of the element
// memories, a bad one only reads them. Integer: lookup, then write-back and
// result register. Float add: lookup, the two-stage binary32 adder, then
// write-back. The next item is taken only after write-back.
// Reset: synchronous; registers go to defaults, then the expected-rank
// memory is zeroed over all MAX_ELEMENTS entries before the first item.
// Stall: a result waits in the output register; the next item is still
// accepted and processed up to its write-back, which waits for the register.
`default_nettype none
`include "collective_elementwise_reduce_macros.svh"
module collective_elementwise_reduce import cer_pkg::*; #(
   parameter int MAX_RANKS    = 16,
   parameter int MAX_ELEMENTS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cer_req_if.sink                    req_chan,
   cer_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

   // one-hot sequencer
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_LOOK = 5'b00010,
      S_ADD  = 5'b00100,
      S_NORM = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [DT_W-1:0]    dt_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [RIU_W-1:0]   riu_ff;
   logic [SLICE_W-1:0] slice_ff;

   // clear sweep of the expected-rank memory
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   // item being worked on
   logic [RANK_W-1:0] rank_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [STAT_W-1:0] stat_ff;
   logic [VAL_W-1:0]  res_ff;
   logic [VAL_W-1:0]  opnd_ff;
   logic              last_ff;
   logic [RANK_W-1:0] next_ff;

   // output register
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic              accept;
   logic              done_fire;
   logic              emit;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     item_addr;
   logic [VAL_W-1:0]  acc_rdata;
   logic [RANK_W-1:0] rank_rdata;
   logic              acc_we;
   logic              rank_we;
   logic [AW-1:0]     wr_addr;
   logic [RANK_W-1:0] rank_wdata;
   logic [31:0]       fp_sum;

   // lookup-stage results
   logic [DT_W-1:0]   dt_eff;
   logic              is_float;
   logic [VAL_W-1:0]  mask;
   logic [NR_W-1:0]   nr;
   logic [RIU_W-1:0]  riu_eff;
   logic [STAT_W-1:0] stat_in;
   logic [VAL_W-1:0]  opnd_in;
   logic [VAL_W-1:0]  res_in;
   logic [VAL_W-1:0]  sbit;
   logic              last_in;
   logic              need_fp;
   logic [VAL_W-1:0]  out_value;

   function automatic logic [VAL_W-1:0] type_mask(input logic [DT_W-1:0] dt);
      case (dt)
         DT_INT32: return 64'h0000_0000_ffff_ffff;
         DT_INT64: return 64'hffff_ffff_ffff_ffff;
         DT_FP16:  return 64'h0000_0000_0000_ffff;
         DT_FP32:  return 64'h0000_0000_ffff_ffff;
         default:  return 64'h0000_0000_0000_00ff;
      endcase
   endfunction

   assign accept    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && !clr_ff;
   assign rd_addr   = AW'({7'd0, req_chan.element_index});
   assign item_addr = AW'({7'd0, idx_ff});

   // lookup: classify the item and build the integer result
   always_comb begin
      dt_eff   = (dt_ff > DT_FP32) ? DT_UINT8 : dt_ff;
      is_float = (dt_eff == DT_FP16) || (dt_eff == DT_FP32);
      mask     = type_mask(dt_eff);
      riu_eff  = (riu_ff == '0) ? RIU_W'(1) : riu_ff;
      nr       = ({4'd0, riu_eff} > NR_W'(MAX_RANKS)) ? NR_W'(MAX_RANKS) : {4'd0, riu_eff};
      if ({5'd0, rank_ff} >= nr || {1'b0, idx_ff} >= slice_ff ||
          {7'd0, idx_ff} >= EXT_W'(MAX_ELEMENTS)) begin
         stat_in = ST_RANGE;
      end else if (is_float && mode_ff == MODE_MAX) begin
         stat_in = ST_FLOAT_MAX;
      end else if (rank_ff != rank_rdata) begin
         stat_in = ST_ORDER;
      end else begin
         stat_in = ST_OK;
      end
      if (dt_eff == DT_FP16) opnd_in = {32'd0, half_to_single(val_ff[15:0])};
      else opnd_in = val_ff & mask;
      sbit = (dt_eff == DT_INT32) ? 64'h0000_0000_8000_0000 : 64'h8000_0000_0000_0000;
      if (rank_ff == '0) begin
         res_in = opnd_in;
      end else if (mode_ff == MODE_SUM) begin
         res_in = (acc_rdata + opnd_in) & mask;
      end else if (dt_eff == DT_UINT8) begin
         res_in = (opnd_in > acc_rdata) ? opnd_in : acc_rdata;
      end else begin
         res_in = ((acc_rdata ^ sbit) < (opnd_in ^ sbit)) ? opnd_in : acc_rdata;
      end
      last_in = ({5'd0, rank_ff} + NR_W'(1)) == nr;
      need_fp = (stat_in == ST_OK) && is_float && (rank_ff != '0);
   end

   // write-back waits for a free output register
   assign done_fire = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);
   assign emit      = (stat_ff != ST_OK) || last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_LOOK;
         S_LOOK: state_in = need_fp ? S_ADD : S_DONE;
         S_ADD:  state_in = S_NORM;
         S_NORM: state_in = S_DONE;
         S_DONE: if (done_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // config writes restart the clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff      <= DT_UINT8;
         mode_ff    <= MODE_SUM;
         riu_ff     <= RIU_W'(1);
         slice_ff   <= SLICE_W'(1024);
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_TYPE:   dt_ff    <= csr_wdata[DT_W-1:0];
            CSR_REDUCE_MODE: mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_RANKS:       riu_ff   <= csr_wdata[RIU_W-1:0];
            CSR_SLICE:       slice_ff <= csr_wdata[SLICE_W-1:0];
            default:         dt_ff    <= dt_ff;
         endcase
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(MAX_ELEMENTS - 1)) clr_ff <= 1'b0;
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         rank_ff <= req_chan.rank;
         idx_ff  <= req_chan.element_index;
         val_ff  <= req_chan.element_value;
      end
      if (state_ff == S_LOOK) begin
         stat_ff <= stat_in;
         res_ff  <= res_in;
         opnd_ff <= opnd_in;
         last_ff <= last_in;
         next_ff <= last_in ? '0 : rank_ff + RANK_W'(1);
      end
      if (state_ff == S_NORM) res_ff <= {32'd0, fp_sum};
   end

   cer_fp_add u_fp_add (
      .clock (clock),
      .lhs   (acc_rdata[31:0]),
      .rhs   (opnd_ff[31:0]),
      .sum   (fp_sum)
   );

   assign acc_we     = done_fire && (stat_ff == ST_OK);
   assign rank_we    = clr_ff || acc_we;
   assign wr_addr    = clr_ff ? clr_cnt_ff : item_addr;
   assign rank_wdata = clr_ff ? '0 : next_ff;

   cer_store #(
      .DEPTH (MAX_ELEMENTS),
      .AW    (AW)
   ) u_store (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (rd_addr),
      .acc_rdata  (acc_rdata),
      .rank_rdata (rank_rdata),
      .wr_addr    (wr_addr),
      .acc_we     (acc_we),
      .acc_wdata  (res_ff),
      .rank_we    (rank_we),
      .rank_wdata (rank_wdata)
   );

   // encode the result: narrow fp16, mask to type, zero on error
   always_comb begin
      if (stat_ff != ST_OK) out_value = '0;
      else if (dt_eff == DT_FP16) out_value = {48'd0, single_to_half(res_ff[31:0])};
      else out_value = res_ff & mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire && emit) begin
         rsp_index_ff  <= idx_ff;
         rsp_value_ff  <= out_value;
         rsp_status_ff <= stat_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_index     = rsp_index_ff;
   assign rsp_chan.reduced_value = rsp_value_ff;
   assign rsp_chan.status        = rsp_status_ff;

   `CER_ASSERT_NOW(a_no_accept_in_clear, clock, reset, accept, !clr_ff, "item taken during clear")
   `CER_ASSERT_NOW(a_err_value_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_value_ff == '0, "error result carries data")
   `CER_ASSERT_NEXT(a_accept_to_look, clock, reset, accept, state_ff == S_LOOK, "accepted item not looked up")
   `CER_ASSERT_NOW(a_write_in_done, clock, reset, acc_we, state_ff == S_DONE && !clr_ff, "accumulator write outside write-back")
endmodule
`default_nettype wire
